@@ sv/bgc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_pkg: shared types and constants
// Verdict codes, register map and the configuration bundle of the button
// gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

    localparam int CFG_BITS    = 16;
    localparam int TARGET_BITS = 3;
    localparam int COUNT_BITS  = 3;
    localparam int PADDR_BITS  = 5;
    localparam int PDATA_BITS  = 32;

    typedef enum logic [1:0] {
        VERDICT_NONE  = 2'd0,
        VERDICT_FIVE  = 2'd1,
        VERDICT_ALERT = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        REG_DEBOUNCE = 3'd0,
        REG_CLICK_MAX = 3'd1,
        REG_HOLD_MIN = 3'd2,
        REG_TIMEOUT  = 3'd3,
        REG_WINDOW   = 3'd4,
        REG_TARGET   = 3'd5
    } reg_index_t;

    localparam logic [CFG_BITS-1:0]    RST_DEBOUNCE  = 16'd50;
    localparam logic [CFG_BITS-1:0]    RST_CLICK_MAX = 16'd600;
    localparam logic [CFG_BITS-1:0]    RST_HOLD_MIN  = 16'd3000;
    localparam logic [CFG_BITS-1:0]    RST_TIMEOUT   = 16'd4000;
    localparam logic [CFG_BITS-1:0]    RST_WINDOW    = 16'd10000;
    localparam logic [TARGET_BITS-1:0] RST_TARGET    = 3'd5;

    localparam logic [COUNT_BITS-1:0]  CLICK_COUNT_MAX = 3'd7;

    typedef struct packed {
        logic [CFG_BITS-1:0]    debounce_ticks;
        logic [CFG_BITS-1:0]    click_max_ticks;
        logic [CFG_BITS-1:0]    hold_min_ticks;
        logic [CFG_BITS-1:0]    config_timeout_ticks;
        logic [CFG_BITS-1:0]    window_ticks;
        logic [TARGET_BITS-1:0] clicks_needed;
    } cfg_t;

endpackage

@@ sv/bgc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_if: stream channels
// Valid/ready channels for tick items and classification results.
// ----------------------------------------------------------------------------
interface bgc_in_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic start_window;

    modport source (output valid, output pin_level, output start_window, input ready);
    modport sink   (input valid, input pin_level, input start_window, output ready);
endinterface

interface bgc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic [2:0] clicks_seen;

    modport source (output valid, output verdict, output clicks_seen, input ready);
    modport sink   (input valid, input verdict, input clicks_seen, output ready);
endinterface

@@ sv/bgc_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgc_regs: configuration register file
// APB-style write and read of the six timing and target registers.
// ----------------------------------------------------------------------------
module bgc_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bgc_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [bgc_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [bgc_pkg::PDATA_BITS-1:0]  prdata,
    output logic                            pready,
    output bgc_pkg::cfg_t                   cfg
);
    import bgc_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    reg_index_t index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = reg_index_t'(paddr[PADDR_BITS-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks       <= RST_DEBOUNCE;
            cfg_reg.click_max_ticks      <= RST_CLICK_MAX;
            cfg_reg.hold_min_ticks       <= RST_HOLD_MIN;
            cfg_reg.config_timeout_ticks <= RST_TIMEOUT;
            cfg_reg.window_ticks         <= RST_WINDOW;
            cfg_reg.clicks_needed        <= RST_TARGET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_DEBOUNCE:  cfg_reg.debounce_ticks       <= pwdata[CFG_BITS-1:0];
                REG_CLICK_MAX: cfg_reg.click_max_ticks      <= pwdata[CFG_BITS-1:0];
                REG_HOLD_MIN:  cfg_reg.hold_min_ticks       <= pwdata[CFG_BITS-1:0];
                REG_TIMEOUT:   cfg_reg.config_timeout_ticks <= pwdata[CFG_BITS-1:0];
                REG_WINDOW:    cfg_reg.window_ticks         <= pwdata[CFG_BITS-1:0];
                REG_TARGET:    cfg_reg.clicks_needed        <= pwdata[TARGET_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (index)
            REG_DEBOUNCE:  prdata = PDATA_BITS'(cfg_reg.debounce_ticks);
            REG_CLICK_MAX: prdata = PDATA_BITS'(cfg_reg.click_max_ticks);
            REG_HOLD_MIN:  prdata = PDATA_BITS'(cfg_reg.hold_min_ticks);
            REG_TIMEOUT:   prdata = PDATA_BITS'(cfg_reg.config_timeout_ticks);
            REG_WINDOW:    prdata = PDATA_BITS'(cfg_reg.window_ticks);
            REG_TARGET:    prdata = PDATA_BITS'(cfg_reg.clicks_needed);
            default:       prdata = '0;
        endcase
    end

endmodule

@@ sv/button_gesture_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_classifier: debounced click / long-press classifier
// Sorts button activity inside a detection window into no action, a click
// series or an alert.
// ----------------------------------------------------------------------------
// Feed one request per millisecond tick with the raw active-low pin level and
// a start flag. The debounce and window state update in a single registered
// pass, and a new request is accepted every cycle as long as the result
// register is empty or being drained. A window yields exactly one result
// (verdict and click count) when it closes; a request that closes no window
// yields none, and a stalled result holds off further requests until it is
// taken. Timers are TIMER_BITS wide and saturate.
module button_gesture_classifier
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bgc_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [bgc_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [bgc_pkg::PDATA_BITS-1:0]  prdata,
    output logic                            pready,
    bgc_in_if.sink                          item_in,
    bgc_out_if.source                       result_out
);
    import bgc_pkg::*;

    localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
        return (&v) ? v : TIMER_BITS'(v + 1'b1);
    endfunction

    cfg_t cfg;

    bgc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic                  open_reg,   open_next;
    logic                  last_reg,   last_next;
    logic                  held_reg,   held_next;
    logic                  first_reg,  first_next;
    logic [TIMER_BITS-1:0] since_reg,  since_next;
    logic [TIMER_BITS-1:0] win_reg,    win_next;
    logic [TIMER_BITS-1:0] press_reg,  press_next;
    logic [TIMER_BITS-1:0] sfc_reg,    sfc_next;
    logic [COUNT_BITS-1:0] count_reg,  count_next;

    logic                  out_valid_reg;
    verdict_t              verdict_reg, verdict_next;
    logic [COUNT_BITS-1:0] clicks_reg;

    logic                  accept;
    logic                  fire;
    logic                  edge_ok;
    logic [TIMER_BITS-1:0] counted;

    assign item_in.ready          = !out_valid_reg || result_out.ready;
    assign accept                 = item_in.valid && item_in.ready;
    assign result_out.valid       = out_valid_reg;
    assign result_out.verdict     = verdict_reg;
    assign result_out.clicks_seen = clicks_reg;

    always_comb
    begin
        open_next    = open_reg;
        held_next    = held_reg;
        first_next   = first_reg;
        win_next     = win_reg;
        press_next   = press_reg;
        sfc_next     = sfc_reg;
        count_next   = count_reg;
        fire         = 1'b0;
        verdict_next = VERDICT_NONE;

        // debounce runs whether or not a window is open
        counted    = sat_inc(since_reg);
        edge_ok    = (item_in.pin_level != last_reg) &&
                     (CMP_BITS'(counted) >= CMP_BITS'(cfg.debounce_ticks));
        since_next = edge_ok ? '0 : counted;
        last_next  = edge_ok ? item_in.pin_level : last_reg;

        if (item_in.start_window)
        begin
            open_next  = 1'b1;
            win_next   = '0;
            held_next  = !item_in.pin_level;
            press_next = '0;
            count_next = '0;
            first_next = 1'b0;
            sfc_next   = '0;
        end
        else if (open_reg)
        begin
            win_next = sat_inc(win_reg);
            if (held_reg)
                press_next = sat_inc(press_reg);
            if (first_reg)
                sfc_next = sat_inc(sfc_reg);

            priority if (CMP_BITS'(win_next) >= CMP_BITS'(cfg.window_ticks))
            begin
                fire         = 1'b1;
                verdict_next = (count_reg != '0) ? VERDICT_ALERT : VERDICT_NONE;
            end
            else if ((count_reg != '0) && (count_reg < cfg.clicks_needed) && !held_reg &&
                     first_reg &&
                     (CMP_BITS'(sfc_next) >= CMP_BITS'(cfg.config_timeout_ticks)))
            begin
                fire         = 1'b1;
                verdict_next = VERDICT_ALERT;
            end
            else
            begin
                if (edge_ok)
                begin
                    if (!item_in.pin_level && !held_reg)
                    begin
                        held_next  = 1'b1;
                        press_next = '0;
                    end
                    else if (item_in.pin_level && held_reg)
                    begin
                        held_next = 1'b0;
                        if (CMP_BITS'(press_next) < CMP_BITS'(cfg.click_max_ticks))
                        begin
                            if (count_reg != CLICK_COUNT_MAX)
                                count_next = count_reg + 1'b1;
                            if (!first_reg)
                            begin
                                first_next = 1'b1;
                                sfc_next   = '0;
                            end
                            if (count_next >= cfg.clicks_needed)
                            begin
                                fire         = 1'b1;
                                verdict_next = VERDICT_FIVE;
                            end
                        end
                        else
                        begin
                            fire         = 1'b1;
                            verdict_next = VERDICT_ALERT;
                        end
                    end
                end

                if (!fire && held_next &&
                    (CMP_BITS'(press_next) >= CMP_BITS'(cfg.hold_min_ticks)))
                begin
                    fire         = 1'b1;
                    verdict_next = VERDICT_ALERT;
                end
            end

            if (fire)
                open_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            last_reg      <= 1'b1;
            held_reg      <= 1'b0;
            first_reg     <= 1'b0;
            since_reg     <= '0;
            win_reg       <= '0;
            press_reg     <= '0;
            sfc_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                open_reg  <= open_next;
                last_reg  <= last_next;
                held_reg  <= held_next;
                first_reg <= first_next;
                since_reg <= since_next;
                win_reg   <= win_next;
                press_reg <= press_next;
                sfc_reg   <= sfc_next;
                count_reg <= count_next;
            end

            // load a new result, or drop the one just taken
            if (accept && fire)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && fire)
        begin
            verdict_reg <= verdict_next;
            clicks_reg  <= count_next;
        end
    end

endmodule
